// ----- hdl/i2cmt_pkg.sv -----
// Shared types, constants and phase codes for the I2C master transaction controller.
`default_nettype none

package i2cmt_pkg;

	// Beat widths on the stream ports.
	localparam int IN_W  = 40;
	localparam int OUT_W = 16;

	// Width of the byte count field on the input beat.
	localparam int CNT_FIELD_W = 16;

	// Default width of the remaining-byte counter.
	localparam int COUNT_BITS_DEF = 16;

	// Entries in the queue between the front and the engine.
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic CFG_BYTE_GAP = 1'b0;
	localparam logic CFG_END_GAP  = 1'b1;

	// Bus timing phases.
	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_PRE0    = 5'd1,
		PH_PRE1    = 5'd2,
		PH_PRE2    = 5'd3,
		PH_ST1     = 5'd4,
		PH_ST2     = 5'd5,
		PH_ST3     = 5'd6,
		PH_SEND_LO = 5'd7,
		PH_SEND_HI = 5'd8,
		PH_SACK_LO = 5'd9,
		PH_SACK_HI = 5'd10,
		PH_GAP     = 5'd11,
		PH_WLOAD   = 5'd12,
		PH_RD_LO   = 5'd13,
		PH_RD_HI   = 5'd14,
		PH_MACK_LO = 5'd15,
		PH_MACK_HI = 5'd16,
		PH_ENDGAP  = 5'd17,
		PH_SP0     = 5'd18,
		PH_SP1     = 5'd19,
		PH_SP2     = 5'd20
	} phase_t;

	// One tick as seen by the engine.
	typedef struct packed {
		logic                   start_request;
		logic                   read_not_write;
		logic [6:0]             client_addr;
		logic [CNT_FIELD_W-1:0] byte_count;
		logic [7:0]             tx_byte;
		logic                   sda_in;
	} tick_t;

	// Head of the queue as offered to the engine.
	typedef struct packed {
		logic  valid;
		tick_t tick;
	} head_t;

endpackage

`default_nettype wire

// ----- hdl/i2c_master_transaction_top.sv -----
// Top level of the I2C master transaction controller.
// An accepted tick beat passes through the queue and then the result register on its way out.
// Throughput: one tick beat per cycle while neither side stalls; each tick takes the sequencer one step.
// A two-entry queue sits between the input side and the sequencer, and a result
// register sits on the output, so either side may stall alone.
// Reset (arst_n low) empties the queue, returns the sequencer to idle and clears
// both gap registers to zero.
`default_nettype none

module i2c_master_transaction_top
	import i2cmt_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0: start_request, read_not_write, client_addr[6:0],
	// byte_count[15:0], tx_byte[7:0], sda_in, zero fill.
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// Fields from bit 0: scl_level, sda_level, sda_drive_enable, rx_byte[7:0],
	// rx_valid, tx_taken, busy_res, done_res, failed.
	output logic [OUT_W-1:0]      m_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [7:0]       cfg_data
);

	head_t       head;
	logic        pop;
	logic [7:0]  byte_gap_q;
	logic [7:0]  end_gap_q;

	// Gap registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_gap_q <= 8'd0;
			end_gap_q  <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BYTE_GAP: byte_gap_q <= cfg_data;
				CFG_END_GAP:  end_gap_q  <= cfg_data;
				default:      byte_gap_q <= byte_gap_q;
			endcase
		end
	end

	i2cmt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.head     (head),
		.pop      (pop)
	);

	i2cmt_engine #(
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.byte_gap (byte_gap_q),
		.end_gap  (end_gap_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- hdl/i2cmt_front.sv -----
// Input side: unpacks tick beats and queues them ahead of the engine.
`default_nettype none

module i2cmt_front
	import i2cmt_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [IN_W-1:0] s_tdata,
	output head_t                head,
	input  wire logic            pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tick_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	tick_t             in_tick;
	logic              push;
	logic              do_pop;

	// Split the beat into its fields, lowest bits first.
	always_comb begin
		in_tick.start_request  = s_tdata[0];
		in_tick.read_not_write = s_tdata[1];
		in_tick.client_addr    = s_tdata[8:2];
		in_tick.byte_count     = s_tdata[24:9];
		in_tick.tx_byte        = s_tdata[32:25];
		in_tick.sda_in         = s_tdata[33];
	end

	assign s_tready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign do_pop   = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.tick  = entry_q[rd_ptr_q];

	// Queue storage; no reset needed on the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_tick;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/i2cmt_engine.sv -----
// Transaction sequencer: takes at most one bus phase step per tick and registers the result beat.
`default_nettype none

module i2cmt_engine
	import i2cmt_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire head_t            head,
	output logic                  pop,
	input  wire logic [7:0]       byte_gap,
	input  wire logic [7:0]       end_gap,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	phase_t                  phase_q, phase_d;
	logic [3:0]              bit_q, bit_d;
	logic [7:0]              shift_q, shift_d;
	logic [COUNT_BITS-1:0]   left_q, left_d;
	logic [7:0]              gap_q, gap_d;
	logic                    dir_q, dir_d;
	logic                    fail_q, fail_d;
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;

	logic                    fire;
	logic [COUNT_BITS+CNT_FIELD_W-1:0] count_ext;
	logic [COUNT_BITS-1:0]   left_dec;
	logic                    left_zero;
	logic [3:0]              bit_inc;
	logic [7:0]              gap_dec;
	logic [7:0]              rd_shift;
	logic                    scl, sdo, drv, rxv, taken, busy, done, fail;
	logic [7:0]              rxb;

	assign fire      = head.valid && (!out_valid_q || m_tready);
	assign pop       = fire;
	assign count_ext = {{COUNT_BITS{1'b0}}, head.tick.byte_count};
	assign left_dec  = left_q - COUNT_BITS'(1);
	assign left_zero = (left_q == '0);
	assign bit_inc   = bit_q + 4'd1;
	assign gap_dec   = gap_q - 8'd1;
	assign rd_shift  = {shift_q[6:0], head.tick.sda_in};

	// Next phase and line levels for the tick at the queue head.
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		left_d  = left_q;
		gap_d   = gap_q;
		dir_d   = dir_q;
		fail_d  = fail_q;
		scl     = 1'b0;
		sdo     = 1'b1;
		drv     = 1'b0;
		rxb     = 8'd0;
		rxv     = 1'b0;
		taken   = 1'b0;
		busy    = 1'b1;
		done    = 1'b0;
		fail    = 1'b0;
		case (phase_q)
			PH_PRE0: begin
				sdo = 1'b0; drv = 1'b1; phase_d = PH_PRE1;
			end
			PH_PRE1: begin
				scl = 1'b1; sdo = 1'b0; drv = 1'b1; phase_d = PH_PRE2;
			end
			PH_PRE2: begin
				scl = 1'b1; drv = 1'b1; phase_d = PH_ST1;
			end
			PH_ST1: begin
				scl = 1'b1; drv = 1'b1; phase_d = PH_ST2;
			end
			PH_ST2: begin
				scl = 1'b1; sdo = 1'b0; drv = 1'b1; phase_d = PH_ST3;
			end
			PH_ST3: begin
				sdo = 1'b0; drv = 1'b1; bit_d = 4'd0; phase_d = PH_SEND_LO;
			end
			PH_SEND_LO: begin
				sdo = shift_q[7]; drv = 1'b1; phase_d = PH_SEND_HI;
			end
			PH_WLOAD: begin
				// Latch the next write byte and put its first bit on the line.
				shift_d = head.tick.tx_byte;
				taken   = 1'b1;
				left_d  = left_dec;
				bit_d   = 4'd0;
				sdo     = head.tick.tx_byte[7];
				drv     = 1'b1;
				phase_d = PH_SEND_HI;
			end
			PH_SEND_HI: begin
				scl     = 1'b1;
				sdo     = shift_q[7];
				drv     = 1'b1;
				shift_d = {shift_q[6:0], 1'b0};
				if (bit_inc[3]) begin
					bit_d   = 4'd0;
					phase_d = PH_SACK_LO;
				end else begin
					bit_d   = bit_inc;
					phase_d = PH_SEND_LO;
				end
			end
			PH_SACK_LO: begin
				phase_d = PH_SACK_HI;
			end
			PH_SACK_HI: begin
				// Sample the slave acknowledge and pick the next step.
				scl = 1'b1;
				if (head.tick.sda_in) begin
					fail_d  = 1'b1;
					phase_d = PH_SP0;
				end else if (left_zero) begin
					if (dir_q) begin
						phase_d = PH_SP0;
					end else if (end_gap != 8'd0) begin
						gap_d   = end_gap;
						phase_d = PH_ENDGAP;
					end else begin
						phase_d = PH_SP0;
					end
				end else begin
					bit_d = 4'd0;
					if (byte_gap != 8'd0) begin
						gap_d   = byte_gap;
						phase_d = PH_GAP;
					end else begin
						phase_d = dir_q ? PH_RD_LO : PH_WLOAD;
					end
				end
			end
			PH_GAP: begin
				gap_d = gap_dec;
				if (gap_dec == 8'd0) begin
					phase_d = dir_q ? PH_RD_LO : PH_WLOAD;
				end
			end
			PH_RD_LO: begin
				phase_d = PH_RD_HI;
			end
			PH_RD_HI: begin
				// Shift in one read bit; the eighth completes the byte.
				scl     = 1'b1;
				shift_d = rd_shift;
				if (bit_inc[3]) begin
					bit_d   = 4'd0;
					rxb     = rd_shift;
					rxv     = 1'b1;
					left_d  = left_dec;
					phase_d = PH_MACK_LO;
				end else begin
					bit_d   = bit_inc;
					phase_d = PH_RD_LO;
				end
			end
			PH_MACK_LO: begin
				drv = 1'b1; sdo = left_zero; phase_d = PH_MACK_HI;
			end
			PH_MACK_HI: begin
				// Master ACK on all but the last byte, NACK on the last.
				scl = 1'b1; drv = 1'b1; sdo = left_zero;
				if (left_zero) begin
					phase_d = PH_SP0;
				end else begin
					bit_d = 4'd0;
					if (byte_gap != 8'd0) begin
						gap_d   = byte_gap;
						phase_d = PH_GAP;
					end else begin
						phase_d = dir_q ? PH_RD_LO : PH_WLOAD;
					end
				end
			end
			PH_ENDGAP: begin
				gap_d = gap_dec;
				if (gap_dec == 8'd0) begin
					phase_d = PH_SP0;
				end
			end
			PH_SP0: begin
				sdo = 1'b0; drv = 1'b1; phase_d = PH_SP1;
			end
			PH_SP1: begin
				scl = 1'b1; sdo = 1'b0; drv = 1'b1; phase_d = PH_SP2;
			end
			PH_SP2: begin
				scl = 1'b1; drv = 1'b1; done = 1'b1; fail = fail_q; phase_d = PH_IDLE;
			end
			default: begin
				// Idle line; a start request latches the transaction.
				scl     = 1'b1;
				busy    = 1'b0;
				phase_d = PH_IDLE;
				if (head.tick.start_request) begin
					busy    = 1'b1;
					dir_d   = head.tick.read_not_write;
					left_d  = count_ext[COUNT_BITS-1:0];
					fail_d  = 1'b0;
					bit_d   = 4'd0;
					gap_d   = 8'd0;
					shift_d = {head.tick.client_addr, head.tick.read_not_write};
					phase_d = head.tick.read_not_write ? PH_ST1 : PH_PRE0;
				end
			end
		endcase
		if (!drv) begin
			sdo = 1'b1;
		end
	end

	// Sequencer state advances once per consumed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			left_q  <= '0;
			gap_q   <= 8'd0;
			dir_q   <= 1'b0;
			fail_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			left_q  <= left_d;
			gap_q   <= gap_d;
			dir_q   <= dir_d;
			fail_q  <= fail_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat, lowest field first.
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {fail, done, busy, taken, rxv, rxb, drv, sdo, scl};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/i2cmt_checker.sv -----
// Port-level checks for the I2C master transaction controller, bound to the top level.
`default_nettype none

module i2cmt_checker
	import i2cmt_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic [IN_W-1:0]  s_tdata,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic             cfg_index,
	input wire logic [7:0]       cfg_data
);

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The end of a transaction is reported while still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[13])
		else $error("done without busy");

	// Failure is only flagged together with done.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[14])
		else $error("failed without done");

	// A tick never both receives and sends a data byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[11] && m_tdata[12]))
		else $error("rx_valid and tx_taken together");

	// Released data line reads as high.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[1])
		else $error("sda low while not driven");

endmodule

bind i2c_master_transaction_top i2cmt_checker u_checker (.*);

`default_nettype wire

// ----- sim/tb_i2c_master_transaction_top.sv -----
// Self-checking testbench for the I2C master transaction controller.
`timescale 1ns / 100ps

module tb_i2c_master_transaction_top;
	import i2cmt_pkg::*;

	// Bus levels and status carried by one result beat.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drv;
		logic [7:0] rxb;
		logic       rxv;
		logic       taken;
		logic       busy;
		logic       done;
		logic       fail;
	} bus_levels_t;

	// One row of the directed stimulus table.
	typedef struct {
		tick_t       tick;
		bit          typed;
		bus_levels_t want;
	} tick_row_t;

	localparam int RANDOM_PHASES = 6;
	localparam int TICKS_PER_PHASE = 300;
	localparam int MAX_PRINTS = 40;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata;
	logic            m_tvalid;
	logic            m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic            cfg_valid;
	logic            cfg_ready;
	logic            cfg_index;
	logic [7:0]      cfg_data;

	// Sequencer copy kept in step with every accepted tick beat.
	phase_t      seq_phase;
	logic [3:0]  seq_bits;
	logic [7:0]  seq_shift;
	logic [15:0] seq_left;
	logic [7:0]  seq_gap;
	logic        seq_dir;
	logic [6:0]  seq_addr;
	logic        seq_fail;
	logic [7:0]  byte_gap;
	logic [7:0]  end_gap;

	bus_levels_t pending_levels[$];
	tick_row_t   tick_table[$];
	int          err_count;
	int          idle_mode;

	i2c_master_transaction_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 2 ns clock.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Hard limit on the run time.
	initial begin
		#400000;
		$display("** i2c_master_transaction_top: FAILED **");
		$finish;
	end

	function automatic logic [IN_W-1:0] pack_tick(input tick_t t);
		logic [IN_W-1:0] v;
		v = '0;
		v[0] = t.start_request;
		v[1] = t.read_not_write;
		v[8:2] = t.client_addr;
		v[24:9] = t.byte_count;
		v[32:25] = t.tx_byte;
		v[33] = t.sda_in;
		return v;
	endfunction

	function automatic bus_levels_t unpack_levels(input logic [OUT_W-1:0] d);
		bus_levels_t o;
		o.scl = d[0];
		o.sda = d[1];
		o.drv = d[2];
		o.rxb = d[10:3];
		o.rxv = d[11];
		o.taken = d[12];
		o.busy = d[13];
		o.done = d[14];
		o.fail = d[15];
		return o;
	endfunction

	function automatic tick_t mk_tick(input logic st, input logic rnw, input logic [6:0] addr,
			input logic [15:0] cnt, input logic [7:0] txb, input logic sda);
		tick_t t;
		t.start_request = st;
		t.read_not_write = rnw;
		t.client_addr = addr;
		t.byte_count = cnt;
		t.tx_byte = txb;
		t.sda_in = sda;
		return t;
	endfunction

	function automatic bus_levels_t mk_levels(input logic scl, input logic sda, input logic drv,
			input logic [7:0] rxb, input logic rxv, input logic taken, input logic busy,
			input logic done, input logic fail);
		bus_levels_t o;
		o.scl = scl;
		o.sda = sda;
		o.drv = drv;
		o.rxb = rxb;
		o.rxv = rxv;
		o.taken = taken;
		o.busy = busy;
		o.done = done;
		o.fail = fail;
		return o;
	endfunction

	// Load the gap before the next data byte, or go straight to it.
	function automatic void start_next_byte();
		seq_bits = '0;
		if (byte_gap != 0) begin
			seq_gap = byte_gap;
			seq_phase = PH_GAP;
		end else begin
			seq_phase = seq_dir ? PH_RD_LO : PH_WLOAD;
		end
	endfunction

	// Advance the sequencer copy by one tick and return the bus levels it drives.
	function automatic bus_levels_t next_bus_levels(input tick_t t);
		bus_levels_t o;
		o = '0;
		o.sda = 1'b1;
		o.busy = 1'b1;
		case (seq_phase)
			PH_PRE0: begin
				o.sda = 0; o.drv = 1; seq_phase = PH_PRE1;
			end
			PH_PRE1: begin
				o.scl = 1; o.sda = 0; o.drv = 1; seq_phase = PH_PRE2;
			end
			PH_PRE2: begin
				o.scl = 1; o.drv = 1; seq_phase = PH_ST1;
			end
			PH_ST1: begin
				o.scl = 1; o.drv = 1; seq_phase = PH_ST2;
			end
			PH_ST2: begin
				o.scl = 1; o.sda = 0; o.drv = 1; seq_phase = PH_ST3;
			end
			PH_ST3: begin
				o.sda = 0; o.drv = 1; seq_bits = '0; seq_phase = PH_SEND_LO;
			end
			PH_SEND_LO: begin
				o.sda = seq_shift[7]; o.drv = 1; seq_phase = PH_SEND_HI;
			end
			PH_WLOAD: begin
				seq_shift = t.tx_byte;
				o.taken = 1;
				seq_left = seq_left - 16'd1;
				seq_bits = '0;
				o.sda = seq_shift[7]; o.drv = 1; seq_phase = PH_SEND_HI;
			end
			PH_SEND_HI: begin
				o.scl = 1; o.sda = seq_shift[7]; o.drv = 1;
				seq_shift = {seq_shift[6:0], 1'b0};
				seq_bits = seq_bits + 4'd1;
				if (seq_bits >= 4'd8) begin
					seq_bits = '0;
					seq_phase = PH_SACK_LO;
				end else begin
					seq_phase = PH_SEND_LO;
				end
			end
			PH_SACK_LO: seq_phase = PH_SACK_HI;
			PH_SACK_HI: begin
				o.scl = 1;
				if (t.sda_in) begin
					seq_fail = 1;
					seq_phase = PH_SP0;
				end else if (seq_left == 0) begin
					if (seq_dir) begin
						seq_phase = PH_SP0;
					end else if (end_gap != 0) begin
						seq_gap = end_gap;
						seq_phase = PH_ENDGAP;
					end else begin
						seq_phase = PH_SP0;
					end
				end else begin
					start_next_byte();
				end
			end
			PH_GAP: begin
				seq_gap = seq_gap - 8'd1;
				if (seq_gap == 0)
					seq_phase = seq_dir ? PH_RD_LO : PH_WLOAD;
			end
			PH_RD_LO: seq_phase = PH_RD_HI;
			PH_RD_HI: begin
				o.scl = 1;
				seq_shift = {seq_shift[6:0], t.sda_in};
				seq_bits = seq_bits + 4'd1;
				if (seq_bits >= 4'd8) begin
					seq_bits = '0;
					o.rxb = seq_shift;
					o.rxv = 1;
					seq_left = seq_left - 16'd1;
					seq_phase = PH_MACK_LO;
				end else begin
					seq_phase = PH_RD_LO;
				end
			end
			PH_MACK_LO: begin
				o.drv = 1; o.sda = (seq_left == 0); seq_phase = PH_MACK_HI;
			end
			PH_MACK_HI: begin
				o.scl = 1; o.drv = 1; o.sda = (seq_left == 0);
				if (seq_left == 0)
					seq_phase = PH_SP0;
				else
					start_next_byte();
			end
			PH_ENDGAP: begin
				seq_gap = seq_gap - 8'd1;
				if (seq_gap == 0)
					seq_phase = PH_SP0;
			end
			PH_SP0: begin
				o.sda = 0; o.drv = 1; seq_phase = PH_SP1;
			end
			PH_SP1: begin
				o.scl = 1; o.sda = 0; o.drv = 1; seq_phase = PH_SP2;
			end
			PH_SP2: begin
				o.scl = 1; o.drv = 1; o.done = 1; o.fail = seq_fail;
				seq_phase = PH_IDLE;
			end
			default: begin
				o.scl = 1; o.busy = 0; seq_phase = PH_IDLE;
				if (t.start_request) begin
					o.busy = 1;
					seq_addr = t.client_addr;
					seq_dir = t.read_not_write;
					seq_left = t.byte_count;
					seq_fail = 0;
					seq_bits = '0;
					seq_gap = '0;
					seq_shift = {seq_addr, seq_dir};
					seq_phase = seq_dir ? PH_ST1 : PH_PRE0;
				end
			end
		endcase
		if (!o.drv)
			o.sda = 1'b1;
		return o;
	endfunction

	// Random tick, shaped by where the sequencer stands so most transactions run deep.
	function automatic tick_t pick_tick();
		tick_t t;
		t.read_not_write = 1'($urandom_range(0, 1));
		t.client_addr = 7'($urandom_range(0, 127));
		t.byte_count = 16'($urandom_range(0, 16'hFFFF));
		t.tx_byte = 8'($urandom_range(0, 255));
		t.sda_in = 1'($urandom_range(0, 1));
		if (seq_phase == PH_IDLE) begin
			t.start_request = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: t.byte_count = 16'd0;
				1, 2, 3, 4, 5, 6: t.byte_count = 16'($urandom_range(1, 3));
				7: t.byte_count = 16'($urandom_range(4, 8));
				default: ;
			endcase
		end else begin
			t.start_request = ($urandom_range(0, 3) == 0);
		end
		// Long transfers are cut short by a slave NACK; short ones mostly get an ACK.
		if (seq_phase == PH_SACK_HI)
			t.sda_in = (seq_left > 16'd8) ? 1'b1 : ($urandom_range(0, 19) == 0);
		return t;
	endfunction

	function automatic bit pause_now();
		return $urandom_range(0, 99) < ((idle_mode == 3) ? 6 : 65);
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTS)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	task automatic add_row(input tick_t t, input bit typed, input bus_levels_t want);
		tick_row_t r;
		r.tick = t;
		r.typed = typed;
		r.want = want;
		tick_table.push_back(r);
	endtask

	// Offer one tick beat; on acceptance record what it should produce.
	task automatic send_tick(input tick_t t, input bit typed, input bus_levels_t want);
		bus_levels_t pred;
		@(negedge clk);
		while ((idle_mode == 1 || idle_mode == 3) && pause_now()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_tick(t);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = next_bus_levels(t);
		pending_levels.push_back(typed ? want : pred);
	endtask

	// Stop sending and let every outstanding result beat come back.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_BYTE_GAP)
			byte_gap = val;
		else
			end_gap = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver side: ready pattern depends on the idling phase.
	always @(negedge clk) begin
		if (idle_mode == 2 || idle_mode == 3)
			m_tready <= !pause_now();
		else
			m_tready <= 1'b1;
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : check_results
		bus_levels_t got;
		bus_levels_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = unpack_levels(m_tdata);
			if (pending_levels.size() == 0) begin
				report_mismatch($sformatf("result beat 0x%0h with nothing expected", m_tdata));
			end else begin
				want = pending_levels.pop_front();
				check_field("scl_level", got.scl, want.scl);
				check_field("sda_level", got.sda, want.sda);
				check_field("sda_drive_enable", got.drv, want.drv);
				check_field("rx_byte", got.rxb, want.rxb);
				check_field("rx_valid", got.rxv, want.rxv);
				check_field("tx_taken", got.taken, want.taken);
				check_field("busy_res", got.busy, want.busy);
				check_field("done_res", got.done, want.done);
				check_field("failed", got.fail, want.fail);
			end
		end
	end

	// Main sequence: reset, directed table, then randomized phases.
	initial begin : stimulus
		bus_levels_t no_levels;
		int          gap_set[RANDOM_PHASES];
		int          end_set[RANDOM_PHASES];
		int          mode_set[RANDOM_PHASES];
		int          i;
		int          p;
		int          n;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BYTE_GAP;
		cfg_data = '0;
		err_count = 0;
		idle_mode = 0;
		no_levels = '0;
		seq_phase = PH_IDLE;
		seq_bits = '0;
		seq_shift = '0;
		seq_left = '0;
		seq_gap = '0;
		seq_dir = 1'b0;
		seq_addr = '0;
		seq_fail = 1'b0;
		byte_gap = '0;
		end_gap = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Idle line, then a zero-length read from address 0 with starts ignored while busy.
		add_row(mk_tick(0, 1, 7'h7F, 16'hFFFF, 8'hFF, 1), 1,
			mk_levels(1, 1, 0, 8'h00, 0, 0, 0, 0, 0));
		add_row(mk_tick(1, 1, 7'h00, 16'h0000, 8'h00, 0), 1,
			mk_levels(1, 1, 0, 8'h00, 0, 0, 1, 0, 0));
		add_row(mk_tick(1, 0, 7'h7F, 16'hFFFF, 8'hFF, 1), 0, no_levels);
		add_row(mk_tick(1, 1, 7'h7F, 16'hFFFF, 8'hFF, 0), 0, no_levels);
		add_row(mk_tick(1, 0, 7'h00, 16'h0000, 8'h00, 1), 0, no_levels);
		for (i = 0; i < 16; i++)
			add_row(mk_tick(i[0], i[1], 7'(i * 9), 16'hA5A5 ^ 16'(i), 8'(i * 17), i[0]),
				0, no_levels);
		add_row(mk_tick(0, 0, 7'h2A, 16'h00FF, 8'h80, 1), 0, no_levels);
		add_row(mk_tick(0, 0, 7'h55, 16'hFF00, 8'h01, 0), 0, no_levels);
		add_row(mk_tick(1, 1, 7'h01, 16'h0001, 8'h7F, 1), 0, no_levels);
		add_row(mk_tick(0, 0, 7'h40, 16'h8000, 8'hFE, 0), 0, no_levels);
		add_row(mk_tick(0, 1, 7'h3F, 16'h7FFF, 8'h00, 1), 1,
			mk_levels(1, 1, 1, 8'h00, 0, 0, 1, 1, 0));
		add_row(mk_tick(0, 0, 7'h00, 16'h0000, 8'h00, 0), 1,
			mk_levels(1, 1, 0, 8'h00, 0, 0, 0, 0, 0));
		foreach (tick_table[k])
			send_tick(tick_table[k].tick, tick_table[k].typed, tick_table[k].want);

		// Gap settings and idling pattern of each random phase.
		gap_set = '{0, 255, 1, $urandom_range(0, 15), 3, 0};
		end_set = '{0, 255, 1, $urandom_range(0, 15), 0, 200};
		mode_set = '{0, 1, 2, 3, 0, 2};

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			idle_mode = mode_set[p];
			write_register(CFG_BYTE_GAP, 8'(gap_set[p]));
			write_register(CFG_END_GAP, 8'(end_set[p]));
			for (n = 0; n < TICKS_PER_PHASE; n++) begin
				if (n == TICKS_PER_PHASE / 2)
					drain_results();
				send_tick(pick_tick(), 0, no_levels);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_levels.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived", pending_levels.size()));
		if (err_count == 0)
			$display("** i2c_master_transaction_top: PASSED **");
		else
			$display("** i2c_master_transaction_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/i2cmt_pkg.sv
hdl/i2cmt_front.sv
hdl/i2cmt_engine.sv
hdl/i2c_master_transaction_top.sv
hdl/i2cmt_checker.sv
sim/tb_i2c_master_transaction_top.sv
